@@ src/tml_pkg.sv @@
// ----------------------------------------------------------------------------
// tml_pkg: shared types and constants for the trimmed mean light level block
// Holds the controller/datapath command and status bundles and fixed widths.
// ----------------------------------------------------------------------------
package tml_pkg;

  localparam int RAW_W   = 8;
  localparam int LEVEL_W = 7;
  localparam int SUM_W   = 15;
  localparam int MIN_W   = 8;
  localparam int CNT_W   = 8;

  // divider runs one quotient bit per step over the whole dividend
  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W    = 4;

  localparam logic [RAW_W:0]   RAW_FULL     = 9'd256;
  localparam logic [CNT_W-1:0] MIN_WINDOW   = 8'd3;
  localparam logic [CNT_W-1:0] WINDOW_RESET = 8'd10;
  localparam logic [MIN_W-1:0] MIN_RESET    = 8'd255;
  localparam logic [MIN_W:0]   RAW_DIVISOR  = 9'd255;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;     // latch raw sample
    logic calc_level;  // convert raw sample to level
    logic accumulate;  // fold level into sum, min, max
    logic div_load;    // load trimmed sum and divisor
    logic div_step;    // one restoring division step
    logic put;         // write result register, advance or clear window
  } tml_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic window_done;  // this sample closes the window
    logic out_free;     // result register can take a new beat
  } tml_status_t;

endpackage

@@ src/tml_ctrl.sv @@
// ----------------------------------------------------------------------------
// tml_ctrl: sequencer for the trimmed mean light level block
// Steps each sample through level conversion, accumulation, the optional
// window-end division and the result write.
// ----------------------------------------------------------------------------
module tml_ctrl
  import tml_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  tml_status_t status,
  output tml_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LEVEL = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DLOAD = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] step_count_next;
  logic              accept;

  // input beat taken only while idle
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // next state and commands
  always_comb begin
    state_next      = state;
    step_count_next = step_count;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          state_next  = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.calc_level = 1'b1;
        state_next     = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = S_PUT;
        if (status.window_done) begin
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.div_load    = 1'b1;
        step_count_next = '0;
        state_next      = S_DIV;
      end
      S_DIV: begin
        cmd.div_step    = 1'b1;
        step_count_next = step_count + 1'b1;
        if (step_count == LAST_STEP) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (status.out_free) begin
          cmd.put    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_count <= '0;
    end else begin
      state      <= state_next;
      step_count <= step_count_next;
    end
  end

endmodule

@@ src/tml_datapath.sv @@
// ----------------------------------------------------------------------------
// tml_datapath: level conversion, window statistics, divider, result register
// Converts raw samples to 0..100 levels, tracks sum/min/max over the window
// and divides the trimmed sum one bit per step.
// ----------------------------------------------------------------------------
module tml_datapath
  import tml_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  tml_cmd_t           cmd,
  output tml_status_t        status,
  input  logic               wr_en,
  input  logic [CNT_W-1:0]   wr_data,
  input  logic [RAW_W-1:0]   raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] sample_level,
  output logic               average_valid,
  output logic [LEVEL_W-1:0] average_level
);

  logic [CNT_W-1:0]   window_count;
  logic [CNT_W-1:0]   eff_count;
  logic [RAW_W-1:0]   raw_reg;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_calc;
  logic [SUM_W-1:0]   level_sum;
  logic [MIN_W-1:0]   level_min;
  logic [LEVEL_W-1:0] level_max;
  logic [CNT_W-1:0]   sample_index;
  logic [CNT_W:0]     taken;
  logic [RAW_W:0]     inv_raw;
  logic [SUM_W-1:0]   scaled;
  logic [LEVEL_W-1:0] q_est;
  logic [MIN_W:0]     q_rem;
  logic [SUM_W-1:0]   trimmed;
  logic [CNT_W-1:0]   divisor;
  logic [SUM_W-1:0]   div_quo;
  logic [CNT_W-1:0]   div_rem;
  logic [CNT_W:0]     trial;
  logic               trial_ge;

  // window count register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= WINDOW_RESET;
    end else if (wr_en) begin
      window_count <= wr_data;
    end
  end

  assign eff_count = (window_count < MIN_WINDOW) ? MIN_WINDOW : window_count;

  // window ends when the samples taken reach the effective count
  assign taken              = {1'b0, sample_index} + 1'b1;
  assign status.window_done = (taken >= {1'b0, eff_count});

  // level = floor((256 - raw) * 100 / 255): estimate by >> 8, then one fix-up
  assign inv_raw = RAW_FULL - {1'b0, raw_reg};
  assign scaled  = {inv_raw, 6'b0} + {1'b0, inv_raw, 5'b0} + {4'b0, inv_raw, 2'b0};
  assign q_est   = scaled[SUM_W-1:8];
  assign q_rem   = {1'b0, scaled[7:0]} + {2'b0, q_est};
  assign level_calc = (q_rem >= RAW_DIVISOR) ? (q_est + 1'b1) : q_est;

  // raw capture and level register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_reg <= raw_sample;
    end
    if (cmd.calc_level) begin
      level <= level_calc;
    end
  end

  // running window statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum    <= '0;
      level_min    <= MIN_RESET;
      level_max    <= '0;
      sample_index <= '0;
    end else if (cmd.accumulate) begin
      level_sum <= level_sum + {{(SUM_W-LEVEL_W){1'b0}}, level};
      if ({1'b0, level} < level_min) begin
        level_min <= {1'b0, level};
      end
      if (level > level_max) begin
        level_max <= level;
      end
    end else if (cmd.put) begin
      if (status.window_done) begin
        level_sum    <= '0;
        level_min    <= MIN_RESET;
        level_max    <= '0;
        sample_index <= '0;
      end else begin
        sample_index <= taken[CNT_W-1:0];
      end
    end
  end

  // trimmed sum and divisor (samples taken less two)
  assign trimmed = level_sum - {{(SUM_W-MIN_W){1'b0}}, level_min}
                 - {{(SUM_W-LEVEL_W){1'b0}}, level_max};

  // restoring division step
  assign trial    = {div_rem, div_quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_quo <= trimmed;
      div_rem <= '0;
      divisor <= sample_index - 1'b1;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[SUM_W-2:0], trial_ge};
      if (trial_ge) begin
        div_rem <= CNT_W'(trial - {1'b0, divisor});
      end else begin
        div_rem <= trial[CNT_W-1:0];
      end
    end
  end

  // result register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) begin
      sample_level  <= level;
      average_valid <= status.window_done;
      average_level <= status.window_done ? div_quo[LEVEL_W-1:0] : '0;
    end
  end

endmodule

@@ src/trimmed_mean_light_level.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_light_level: olympic trimmed mean of inverted light levels
// Converts each raw 8-bit sample to a 0..100 level and, at each window end,
// returns the window mean with its minimum and maximum dropped.
// ----------------------------------------------------------------------------
// Each raw sample beat yields one result beat carrying its level; the beat
// that closes a window also carries average_valid and the truncated trimmed
// mean. An ordinary sample steps through capture, level conversion,
// accumulate and result write; a window-closing sample also passes the
// load and 15 one-bit steps of the restoring divider before the write.
// The result register lets a new sample enter while the previous
// result is still stalled. window_count below 3 acts as 3, and a write
// takes effect from the next sample without clearing the running window.
module trimmed_mean_light_level
  import tml_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CNT_W-1:0]   wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [RAW_W-1:0]   raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] sample_level,
  output logic               average_valid,
  output logic [LEVEL_W-1:0] average_level
);

  tml_cmd_t    cmd;
  tml_status_t status;

  // sequencer
  tml_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and storage
  tml_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .raw_sample    (raw_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_level  (sample_level),
    .average_valid (average_valid),
    .average_level (average_level)
  );

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: regression bench for trimmed_mean_light_level
// Opens with a short table of directed beats and window-count writes, then
// runs random phases. Each phase may set a new window count, and its samples
// lean toward the dark and bright extremes. Every result beat is checked,
// against the typed rows' wanted values or an in-bench model of the level
// conversion and the trimmed-mean window. Both sides idle at random, and
// the receiver holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module testbench;
  import tml_pkg::*;

  // one result beat: level, window-end flag, trimmed mean
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               avg_valid;
    logic [LEVEL_W-1:0] avg;
  } light_result_t;

  typedef enum logic [0:0] {ROW_BEAT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [7:0]    value;   // raw sample or window count
    logic          typed;   // use want instead of the model
    light_result_t want;
  } plan_row_t;

  localparam int PLAN_LEN      = 29;
  localparam int RANDOM_BEATS  = 1900;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_CYCLES   = 8;
  localparam light_result_t NO_WANT = '0;

  // directed stimulus
  plan_row_t plan [PLAN_LEN] = '{
    // count 0 acts as 3: full bright then full dark windows
    '{ROW_WRITE, 8'd0,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd0,   1'b1, '{7'd100, 1'b0, 7'd0}},
    '{ROW_BEAT,  8'd0,   1'b1, '{7'd100, 1'b0, 7'd0}},
    '{ROW_BEAT,  8'd0,   1'b1, '{7'd100, 1'b1, 7'd100}},
    '{ROW_BEAT,  8'd255, 1'b1, '{7'd0,   1'b0, 7'd0}},
    '{ROW_BEAT,  8'd255, 1'b1, '{7'd0,   1'b0, 7'd0}},
    '{ROW_BEAT,  8'd255, 1'b1, '{7'd0,   1'b1, 7'd0}},
    // counts 1 and 2 also act as 3
    '{ROW_WRITE, 8'd1,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd128, 1'b0, NO_WANT},
    '{ROW_BEAT,  8'd1,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd254, 1'b0, NO_WANT},
    '{ROW_WRITE, 8'd2,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd64,  1'b0, NO_WANT},
    '{ROW_BEAT,  8'd200, 1'b0, NO_WANT},
    '{ROW_BEAT,  8'd127, 1'b0, NO_WANT},
    // widest window, then lowered mid-window
    '{ROW_WRITE, 8'd255, 1'b0, NO_WANT},
    '{ROW_BEAT,  8'd0,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd255, 1'b0, NO_WANT},
    '{ROW_BEAT,  8'd85,  1'b0, NO_WANT},
    '{ROW_BEAT,  8'd170, 1'b0, NO_WANT},
    '{ROW_BEAT,  8'd15,  1'b0, NO_WANT},
    '{ROW_BEAT,  8'd240, 1'b0, NO_WANT},
    '{ROW_WRITE, 8'd4,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd99,  1'b0, NO_WANT},
    '{ROW_WRITE, 8'd3,   1'b0, NO_WANT},
    '{ROW_BEAT,  8'd33,  1'b0, NO_WANT},
    '{ROW_BEAT,  8'd66,  1'b0, NO_WANT},
    '{ROW_BEAT,  8'd99,  1'b0, NO_WANT},
    '{ROW_WRITE, 8'd10,  1'b0, NO_WANT}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [CNT_W-1:0]   wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RAW_W-1:0]   raw_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [LEVEL_W-1:0] sample_level;
  logic               average_valid;
  logic [LEVEL_W-1:0] average_level;

  // window model state
  logic [CNT_W-1:0]   cfg_window;
  logic [SUM_W-1:0]   acc_sum;
  logic [MIN_W-1:0]   acc_min;
  logic [LEVEL_W-1:0] acc_max;
  logic [CNT_W-1:0]   acc_taken;

  light_result_t pending_results [$];
  int  mismatches  = 0;
  int  results_out = 0;
  bit  quiet_mode  = 1'b0;

  trimmed_mean_light_level u_top (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .raw_sample    (raw_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_level  (sample_level),
    .average_valid (average_valid),
    .average_level (average_level)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // generous run limit
  initial begin
    #4000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // inverted level, floor((256 - raw) * 100 / 255)
  function automatic logic [LEVEL_W-1:0] raw_to_level(logic [RAW_W-1:0] raw);
    int unsigned scaled;
    scaled = ((32'd256 - 32'(raw)) * 32'd100) / 32'd255;
    return scaled[LEVEL_W-1:0];
  endfunction

  function automatic void clear_window();
    acc_sum   = '0;
    acc_min   = MIN_RESET;
    acc_max   = '0;
    acc_taken = '0;
  endfunction

  // fold one sample into the window and form its result
  function automatic light_result_t fold_sample(logic [RAW_W-1:0] raw);
    light_result_t res;
    logic [LEVEL_W-1:0] lvl;
    int unsigned eff;
    int unsigned taken;
    int unsigned trimmed;
    lvl = raw_to_level(raw);
    eff = (cfg_window < MIN_WINDOW) ? 32'(MIN_WINDOW) : 32'(cfg_window);
    if (lvl > acc_max) acc_max = lvl;
    if (32'(lvl) < 32'(acc_min)) acc_min = MIN_W'(lvl);
    acc_sum = acc_sum + SUM_W'(lvl);
    taken = 32'(acc_taken) + 1;
    res.level = lvl;
    res.avg_valid = 1'b0;
    res.avg = '0;
    if (taken >= eff) begin
      trimmed = 32'(acc_sum) - 32'(acc_min) - 32'(acc_max);
      trimmed = trimmed / (taken - 2);
      res.avg = trimmed[LEVEL_W-1:0];
      res.avg_valid = 1'b1;
      clear_window();
    end else begin
      acc_taken = taken[CNT_W-1:0];
    end
    return res;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // raw samples lean toward full bright and full dark
  function automatic logic [RAW_W-1:0] pick_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return RAW_W'($urandom_range(0, 255));
  endfunction

  task automatic report(string msg);
    $display("mismatch at result %0d: %s", results_out, msg);
    mismatches++;
  endtask

  // offer one sample beat, predict on acceptance, then idle for a random gap that may be none
  task automatic send_beat(logic [RAW_W-1:0] raw, logic typed, light_result_t want);
    light_result_t pred;
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    raw_sample = raw;
    do @(posedge clk); while (in_stall);
    pred = fold_sample(raw);
    pending_results.push_back(typed ? want : pred);
    gap = quiet_mode ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      raw_sample = RAW_W'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // wait for the block to drain, then write the window count
  task automatic write_window(logic [CNT_W-1:0] count);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
    @(negedge clk);
    wr_en = 1'b1;
    wr_data = count;
    cfg_window = count;
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : check_beat
    light_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (sample_level !== want.level)
          report($sformatf("sample_level got %0d want %0d", sample_level, want.level));
        if (average_valid !== want.avg_valid)
          report($sformatf("average_valid got %0d want %0d", average_valid,
                           want.avg_valid));
        if (average_level !== want.avg)
          report($sformatf("average_level got %0d want %0d", average_level, want.avg));
      end
      results_out++;
    end
  end

  // receiver stalls, with a long hold now and then to back the block up
  initial begin : receiver_stall
    int stall_left;
    int next_hold;
    int gap;
    stall_left = 0;
    next_hold = 300;
    forever begin
      @(negedge clk);
      if (results_out >= next_hold) begin
        stall_left = LONG_HOLD;
        next_hold += 1000;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (quiet_mode) begin
        out_stall = 1'b0;
      end else begin
        gap = pick_gap();
        out_stall = (gap > 0);
        stall_left = (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // reset, directed table, random phases, drain
  initial begin : stimulus
    int random_sent;
    int phase_len;
    int r;
    logic [CNT_W-1:0] count;
    cfg_window = WINDOW_RESET;
    clear_window();
    random_sent = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_WRITE) write_window(plan[i].value);
      else send_beat(plan[i].value, plan[i].typed, plan[i].want);
    end

    // random phases; a skipped write keeps the running window going
    while (random_sent < RANDOM_BEATS) begin
      quiet_mode = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) count = CNT_W'($urandom_range(0, 2));
        else if (r < 20) count = 8'd255;
        else if (r < 30) count = CNT_W'($urandom_range(128, 254));
        else count = CNT_W'($urandom_range(3, 24));
        write_window(count);
      end
      phase_len = (cfg_window > 40) ? $urandom_range(100, 300) : $urandom_range(20, 120);
      repeat (phase_len) begin
        send_beat(pick_raw(), 1'b0, NO_WANT);
        random_sent++;
      end
    end

    quiet_mode = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
